// ----- hw/rtl/corre_rectangle_decoder_macros.svh -----
// Assertion macros used by the CoRRE rectangle decoder core.
`ifndef CORRE_RECTANGLE_DECODER_MACROS_SVH
`define CORRE_RECTANGLE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/crd_pkg.sv -----
// Types, codes and helpers for the CoRRE rectangle decoder.
package crd_pkg;

  // Decoder phase within one rectangle payload
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_COUNT  = 3'd1,
    PH_BGPIX  = 3'd2,
    PH_SUBPIX = 3'd3,
    PH_SUBX   = 3'd4,
    PH_SUBY   = 3'd5,
    PH_SUBW   = 3'd6,
    PH_SUBH   = 3'd7
  } crd_phase_e;

  // Configuration register indexes
  localparam logic [0:0] CFG_PIXEL_SIZE_MODE     = 1'b0;
  localparam logic [0:0] CFG_PIXEL_LITTLE_ENDIAN = 1'b1;

  // Pixel size codes
  localparam logic [1:0] PIX_MODE_1B = 2'd0;
  localparam logic [1:0] PIX_MODE_2B = 2'd1;

  // One payload byte with its rectangle header fields
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
  } crd_item_t;

  // One fill box
  typedef struct packed {
    logic [16:0] box_x;
    logic [16:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [31:0] box_color;
    logic        is_background;
    logic        last_box;
  } crd_box_t;

  // Index of the final byte of a pixel for a given size code
  function automatic logic [1:0] pixel_last_idx(input logic [1:0] mode);
    logic [1:0] idx;
    case (mode)
      PIX_MODE_1B: idx = 2'd0;
      PIX_MODE_2B: idx = 2'd1;
      default:     idx = 2'd3;
    endcase
    return idx;
  endfunction

endpackage

// ----- hw/rtl/corre_rectangle_decoder.sv -----
// Top level of the CoRRE rectangle decoder.
// Path: the byte that completes a box waits in the input register, then is decoded into the result register.
// Throughput: one payload byte per cycle while the consumer drains results, set by the single
// decode pass between the input register and the result register.
// Reset: asynchronous, active low; clears both registers' valid flags, the
// decoder state (idle) and the configuration (one-byte, big-endian pixels).
module corre_rectangle_decoder
  import crd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [15:0] rect_x_i,
  input  logic [15:0] rect_y_i,
  input  logic [15:0] rect_w_i,
  input  logic [15:0] rect_h_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] box_x_o,
  output logic [16:0] box_y_o,
  output logic [15:0] box_w_o,
  output logic [15:0] box_h_o,
  output logic [31:0] box_color_o,
  output logic        is_background_o,
  output logic        last_box_o
);

  crd_item_t in_item, held_item;
  crd_box_t  dec_box, out_box;
  logic      held_valid, advance, emit;

  // Gather the input transaction
  always_comb begin
    in_item.data_byte  = data_byte_i;
    in_item.first_byte = first_byte_i;
    in_item.rect_x     = rect_x_i;
    in_item.rect_y     = rect_y_i;
    in_item.rect_w     = rect_w_i;
    in_item.rect_h     = rect_h_i;
  end

  // Move a held byte on whenever the result register is free or draining
  assign advance = held_valid && (!out_valid_o || out_ready_i);

  crd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  crd_decode_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .item_i     (held_item),
    .emit_o     (emit),
    .box_o      (dec_box)
  );

  crd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .emit_i      (emit),
    .box_i       (dec_box),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .box_o       (out_box)
  );

  // Spread the result onto its ports
  assign box_x_o         = out_box.box_x;
  assign box_y_o         = out_box.box_y;
  assign box_w_o         = out_box.box_w;
  assign box_h_o         = out_box.box_h;
  assign box_color_o     = out_box.box_color;
  assign is_background_o = out_box.is_background;
  assign last_box_o      = out_box.last_box;

endmodule

// ----- hw/rtl/crd_in_stage.sv -----
// Input register stage: holds one accepted payload byte for the decoder.
module crd_in_stage
  import crd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  crd_item_t in_item_i,
  input  logic      advance_i,
  output logic      held_valid_o,
  output crd_item_t held_item_o
);

  logic      valid_q, valid_d;
  crd_item_t item_q;

  // Accept when empty or when the held byte moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload of each transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

// ----- hw/rtl/crd_decode_core.sv -----
// Decoder state and single-pass byte decode for CoRRE rectangles.
`include "corre_rectangle_decoder_macros.svh"
module crd_decode_core
  import crd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i,
  input  logic       advance_i,
  input  crd_item_t  item_i,
  output logic       emit_o,
  output crd_box_t   box_o
);

  logic [1:0]  pix_mode_q;
  logic        pix_le_q;
  crd_phase_e  phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  sub_x_q, sub_x_d, sub_y_q, sub_y_d, sub_w_q, sub_w_d;
  logic [15:0] orig_x_q, orig_x_d, orig_y_q, orig_y_d;
  logic [15:0] full_w_q, full_w_d, full_h_q, full_h_d;

  crd_phase_e  cur_phase;
  logic [1:0]  cur_idx;
  logic [31:0] cur_rem, cur_acc, rem_dec, acc_take;
  logic [1:0]  idx_take;
  logic        pix_done;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_mode_q <= 2'd0;
      pix_le_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PIXEL_SIZE_MODE:     pix_mode_q <= cfg_data_i;
        CFG_PIXEL_LITTLE_ENDIAN: pix_le_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Restart on a first byte, then decode the byte in the current phase
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    sub_x_d  = sub_x_q;
    sub_y_d  = sub_y_q;
    sub_w_d  = sub_w_q;
    orig_x_d = orig_x_q;
    orig_y_d = orig_y_q;
    full_w_d = full_w_q;
    full_h_d = full_h_q;
    emit_o   = 1'b0;

    cur_phase = phase_q;
    cur_idx   = idx_q;
    cur_rem   = rem_q;
    cur_acc   = acc_q;
    if (item_i.first_byte) begin
      orig_x_d  = item_i.rect_x;
      orig_y_d  = item_i.rect_y;
      full_w_d  = item_i.rect_w;
      full_h_d  = item_i.rect_h;
      cur_phase = PH_COUNT;
      cur_idx   = 2'd0;
      cur_rem   = '0;
      cur_acc   = '0;
    end
    phase_d = cur_phase;
    idx_d   = cur_idx;
    rem_d   = cur_rem;
    acc_d   = cur_acc;

    // Pixel byte assembly in either byte order
    if (pix_le_q) begin
      acc_take = cur_acc | ({24'd0, item_i.data_byte} << {cur_idx, 3'b000});
    end else begin
      acc_take = {cur_acc[23:0], item_i.data_byte};
    end
    pix_done = (cur_idx >= pixel_last_idx(pix_mode_q));
    idx_take = pix_done ? 2'd0 : cur_idx + 2'd1;
    rem_dec  = cur_rem - 32'd1;

    box_o.box_x         = {1'b0, orig_x_q} + {9'd0, sub_x_q};
    box_o.box_y         = {1'b0, orig_y_q} + {9'd0, sub_y_q};
    box_o.box_w         = {8'd0, sub_w_q};
    box_o.box_h         = {8'd0, item_i.data_byte};
    box_o.box_color     = cur_acc;
    box_o.is_background = 1'b0;
    box_o.last_box      = (rem_dec == 32'd0);

    case (cur_phase)
      PH_COUNT: begin
        rem_d = {cur_rem[23:0], item_i.data_byte};
        if (cur_idx == 2'd3) begin
          idx_d   = 2'd0;
          acc_d   = '0;
          phase_d = PH_BGPIX;
        end else begin
          idx_d = cur_idx + 2'd1;
        end
      end
      PH_BGPIX: begin
        acc_d = acc_take;
        idx_d = idx_take;
        if (pix_done) begin
          emit_o              = 1'b1;
          box_o.box_x         = {1'b0, orig_x_d};
          box_o.box_y         = {1'b0, orig_y_d};
          box_o.box_w         = full_w_d;
          box_o.box_h         = full_h_d;
          box_o.box_color     = acc_take;
          box_o.is_background = 1'b1;
          box_o.last_box      = (cur_rem == 32'd0);
          acc_d               = '0;
          phase_d             = (cur_rem == 32'd0) ? PH_IDLE : PH_SUBPIX;
        end
      end
      PH_SUBPIX: begin
        acc_d = acc_take;
        idx_d = idx_take;
        if (pix_done) begin
          phase_d = PH_SUBX;
        end
      end
      PH_SUBX: begin
        sub_x_d = item_i.data_byte;
        phase_d = PH_SUBY;
      end
      PH_SUBY: begin
        sub_y_d = item_i.data_byte;
        phase_d = PH_SUBW;
      end
      PH_SUBW: begin
        sub_w_d = item_i.data_byte;
        phase_d = PH_SUBH;
      end
      PH_SUBH: begin
        emit_o  = 1'b1;
        rem_d   = rem_dec;
        acc_d   = '0;
        idx_d   = 2'd0;
        phase_d = (rem_dec == 32'd0) ? PH_IDLE : PH_SUBPIX;
      end
      default: ;
    endcase
  end

  // Advance decoder state once per byte taken from the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      idx_q    <= 2'd0;
      rem_q    <= '0;
      acc_q    <= '0;
      sub_x_q  <= '0;
      sub_y_q  <= '0;
      sub_w_q  <= '0;
      orig_x_q <= '0;
      orig_y_q <= '0;
      full_w_q <= '0;
      full_h_q <= '0;
    end else if (advance_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      rem_q    <= rem_d;
      acc_q    <= acc_d;
      sub_x_q  <= sub_x_d;
      sub_y_q  <= sub_y_d;
      sub_w_q  <= sub_w_d;
      orig_x_q <= orig_x_d;
      orig_y_q <= orig_y_d;
      full_w_q <= full_w_d;
      full_h_q <= full_h_d;
    end
  end

  // A last box always returns the decoder to idle
  `CRD_ASSERT_NEXT(a_last_goes_idle, clk_i, rst_ni, advance_i && emit_o && box_o.last_box, phase_q == PH_IDLE)
  // Background fills come only from the background pixel phase
  `CRD_ASSERT_NOW(a_bg_from_bgpix, clk_i, rst_ni, advance_i && emit_o && box_o.is_background, phase_q == PH_BGPIX && !item_i.first_byte)
  // A stray byte while idle yields nothing and leaves the decoder idle
  `CRD_ASSERT_NOW(a_idle_no_emit, clk_i, rst_ni, phase_q == PH_IDLE && !item_i.first_byte, !emit_o)
  `CRD_ASSERT_NEXT(a_idle_stays, clk_i, rst_ni, advance_i && phase_q == PH_IDLE && !item_i.first_byte, phase_q == PH_IDLE)

endmodule

// ----- hw/rtl/crd_out_stage.sv -----
// Result register: holds one fill box until the consumer takes it.
module crd_out_stage
  import crd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     advance_i,
  input  logic     emit_i,
  input  crd_box_t box_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output crd_box_t box_o
);

  logic     valid_q, valid_d;
  crd_box_t box_q;

  // Set on each decoded byte that emits a box, clear on one that does not, drop once taken
  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = emit_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && emit_i) begin
      box_q <= box_i;
    end
  end

  assign out_valid_o = valid_q;
  assign box_o       = box_q;

endmodule
